// ===== hw/rtl/tswr_pkg.sv =====
package tswr_pkg;

	localparam int QUEUE_DEPTH_DEF  = 64;
	localparam int MAX_SEGMENTS_DEF = 64;

	localparam logic [15:0] RTO_RESET    = 16'd1000;
	localparam logic [10:0] MAXPAY_RESET = 11'd1000;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 72;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_ACK   = 2'd1,
		OP_TICK  = 2'd2,
		OP_EMPTY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_ISN     = 2'd0,
		CFG_RTO     = 2'd1,
		CFG_MAXPAY  = 2'd2,
		CFG_NONE    = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PUSH,
		ST_ACK_UNW,
		ST_ACK_CHK,
		ST_ACK_RD,
		ST_ACK_POP,
		ST_TICK_ADD,
		ST_TICK_CHK,
		ST_EMPTY
	} state_t;

	// one outstanding segment as kept in the queue
	typedef struct packed {
		logic [31:0] seqno;
		logic [10:0] payload;
		logic        syn;
		logic        fin;
		logic        rst;
	} q_ent_t;

	typedef struct packed {
		logic [31:0] seqno;
		logic        syn;
		logic        fin;
		logic        rst;
		logic [10:0] payload;
		logic        retx;
		logic        last;
		logic [16:0] in_flight;
		logic [7:0]  retx_count;
	} res_t;

	typedef struct packed {
		logic load_in;
		logic push_step;
		logic push_flush;
		logic ack_rst;
		logic ack_win;
		logic ack_unwrap;
		logic ack_commit;
		logic q_rd;
		logic q_pop;
		logic tick_add;
		logic tick_fire;
		logic empty_fire;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic ackno_valid;
		logic peer_reset;
		logic seg_ok;
		logic stg_valid;
		logic out_free;
		logic q_empty;
		logic ack_in_range;
		logic pop_ok;
		logic timer_exp;
	} sts_t;

endpackage

// ===== hw/rtl/tswr_ctrl.sv =====
module tswr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tswr_pkg::sts_t  sts,
	output tswr_pkg::cmd_t  cmd
);

	tswr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tswr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tswr_pkg::ST_IDLE: begin
				if (in_valid) state_d = tswr_pkg::ST_DECODE;
			end
			tswr_pkg::ST_DECODE: begin
				case (sts.op)
					tswr_pkg::OP_PUSH: state_d = tswr_pkg::ST_PUSH;
					tswr_pkg::OP_ACK: begin
						if (!sts.peer_reset && sts.ackno_valid) state_d = tswr_pkg::ST_ACK_UNW;
						else state_d = tswr_pkg::ST_IDLE;
					end
					tswr_pkg::OP_TICK: state_d = tswr_pkg::ST_TICK_ADD;
					default: state_d = tswr_pkg::ST_EMPTY;
				endcase
			end
			tswr_pkg::ST_PUSH: begin
				if (sts.out_free && !sts.seg_ok) state_d = tswr_pkg::ST_IDLE;
			end
			tswr_pkg::ST_ACK_UNW: state_d = tswr_pkg::ST_ACK_CHK;
			tswr_pkg::ST_ACK_CHK: begin
				state_d = sts.ack_in_range ? tswr_pkg::ST_ACK_RD : tswr_pkg::ST_IDLE;
			end
			tswr_pkg::ST_ACK_RD: begin
				state_d = sts.q_empty ? tswr_pkg::ST_IDLE : tswr_pkg::ST_ACK_POP;
			end
			tswr_pkg::ST_ACK_POP: begin
				state_d = sts.pop_ok ? tswr_pkg::ST_ACK_RD : tswr_pkg::ST_IDLE;
			end
			tswr_pkg::ST_TICK_ADD: begin
				state_d = sts.q_empty ? tswr_pkg::ST_IDLE : tswr_pkg::ST_TICK_CHK;
			end
			tswr_pkg::ST_TICK_CHK: begin
				if (!sts.timer_exp || sts.out_free) state_d = tswr_pkg::ST_IDLE;
			end
			tswr_pkg::ST_EMPTY: begin
				if (sts.out_free) state_d = tswr_pkg::ST_IDLE;
			end
			default: state_d = tswr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			tswr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			tswr_pkg::ST_DECODE: begin
				if (sts.op == tswr_pkg::OP_ACK) begin
					cmd.ack_rst = sts.peer_reset;
					cmd.ack_win = !sts.peer_reset;
				end
			end
			tswr_pkg::ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push_step  = sts.seg_ok;
					cmd.push_flush = !sts.seg_ok && sts.stg_valid;
				end
			end
			tswr_pkg::ST_ACK_UNW: cmd.ack_unwrap = 1'b1;
			tswr_pkg::ST_ACK_CHK: cmd.ack_commit = sts.ack_in_range;
			tswr_pkg::ST_ACK_RD:  cmd.q_rd = !sts.q_empty;
			tswr_pkg::ST_ACK_POP: cmd.q_pop = sts.pop_ok;
			tswr_pkg::ST_TICK_ADD: begin
				cmd.tick_add = !sts.q_empty;
				cmd.q_rd     = !sts.q_empty;
			end
			tswr_pkg::ST_TICK_CHK: cmd.tick_fire = sts.timer_exp && sts.out_free;
			tswr_pkg::ST_EMPTY:    cmd.empty_fire = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/tswr_dp.sv =====
module tswr_dp #(
	parameter int QUEUE_DEPTH  = tswr_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_SEGMENTS = tswr_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_idx,
	input  logic [31:0]                       cfg_data,
	input  logic [1:0]                        in_op,
	input  logic [tswr_pkg::IN_DATA_W-1:0]    in_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output tswr_pkg::res_t                    res,
	input  tswr_pkg::cmd_t                    cmd,
	output tswr_pkg::sts_t                    sts
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(MAX_SEGMENTS + 1);

	// config
	logic [31:0] isn_q;
	logic [15:0] init_rto_q;
	logic [10:0] max_pay_q;

	// latched input
	logic [1:0]  op_q;
	logic        ackv_q, prst_q, fin_in_q, serr_q;
	logic [31:0] ackno_q;
	logic [15:0] win_in_q, el_q;

	// protocol state
	logic [63:0] next_q, last_ack_q, ack_q;
	logic [16:0] flight_q, dist_q;
	logic [15:0] pw_q, avail_q;
	logic        syn_q, fin_q, err_q, in_range_q;
	logic [31:0] timer_q, rto_q;
	logic [7:0]  retry_q;
	logic [NW-1:0] nseg_q;

	// queue
	tswr_pkg::q_ent_t mem [QUEUE_DEPTH];
	tswr_pkg::q_ent_t rd_q;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q;

	// output staging
	tswr_pkg::res_t stg_q, out_q;
	logic           stg_v_q, out_v_q;

	logic out_free;
	assign out_free = !out_v_q || out_ready;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// push: next segment from current state
	logic [16:0] win, rest0, rest1, add, rest2;
	logic [15:0] avail_left;
	logic        room, seg_fin, seg_syn, seg_ok;
	logic [11:0] seg_len;

	always_comb begin
		win   = (pw_q == '0) ? 17'd1 : {1'b0, pw_q};
		room  = win > flight_q;
		rest0 = win - flight_q;
		seg_syn = !syn_q;
		rest1 = seg_syn ? rest0 - 17'd1 : rest0;
		add   = rest1;
		if ({1'b0, avail_q} < add) add = {1'b0, avail_q};
		if ({6'd0, max_pay_q} < add) add = {6'd0, max_pay_q};
		rest2      = rest1 - add;
		avail_left = avail_q - add[15:0];
		seg_fin    = (rest2 != '0) && fin_in_q && (avail_left == '0);
		seg_len    = {1'b0, add[10:0]} + {11'd0, seg_syn} + {11'd0, seg_fin};
		seg_ok     = room && !fin_q && (nseg_q < NW'(MAX_SEGMENTS))
		             && (cnt_q < CW'(QUEUE_DEPTH)) && (seg_len != '0);
	end

	// ack unwrap against next_q
	logic [31:0] ack_off;
	logic [63:0] cand, ack_un;
	always_comb begin
		ack_off = ackno_q - isn_q;
		cand    = {next_q[63:32], ack_off};
		ack_un  = cand;
		if ((cand > next_q + 64'h8000_0000) && (cand[63:32] != '0))
			ack_un = {cand[63:32] - 32'd1, ack_off};
		else if (cand + 64'h8000_0000 < next_q)
			ack_un = {cand[63:32] + 32'd1, ack_off};
	end

	logic [11:0] rd_len;
	logic [16:0] flight_after;
	logic [32:0] timer_sum;
	logic [31:0] rto_dbl;
	logic [7:0]  retry_inc;
	assign rd_len       = {1'b0, rd_q.payload} + {11'd0, rd_q.syn} + {11'd0, rd_q.fin};
	assign flight_after = flight_q - {5'd0, rd_len};
	assign timer_sum    = {1'b0, timer_q} + {17'd0, el_q};
	assign rto_dbl      = rto_q[31] ? '1 : {rto_q[30:0], 1'b0};
	assign retry_inc    = (retry_q == 8'hFF) ? retry_q : retry_q + 8'd1;

	tswr_pkg::res_t new_seg;
	always_comb begin
		new_seg.seqno      = next_q[31:0] + isn_q;
		new_seg.syn        = seg_syn;
		new_seg.fin        = seg_fin;
		new_seg.rst        = err_q || serr_q;
		new_seg.payload    = add[10:0];
		new_seg.retx       = 1'b0;
		new_seg.last       = 1'b0;
		new_seg.in_flight  = flight_q + {5'd0, seg_len};
		new_seg.retx_count = retry_q;
	end

	// staged last segment of a push, marked as the end of the item
	tswr_pkg::res_t flush_res;
	always_comb begin
		flush_res      = stg_q;
		flush_res.last = 1'b1;
	end

	logic out_load;
	assign out_load = (cmd.push_step && stg_v_q) || cmd.push_flush || cmd.tick_fire
	                  || cmd.empty_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isn_q      <= '0;
			init_rto_q <= tswr_pkg::RTO_RESET;
			max_pay_q  <= tswr_pkg::MAXPAY_RESET;
			next_q     <= '0;
			last_ack_q <= '0;
			flight_q   <= '0;
			pw_q       <= 16'd1;
			syn_q      <= 1'b0;
			fin_q      <= 1'b0;
			err_q      <= 1'b0;
			timer_q    <= '0;
			rto_q      <= {16'd0, tswr_pkg::RTO_RESET};
			retry_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
			stg_v_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (tswr_pkg::cfg_idx_t'(cfg_idx))
					tswr_pkg::CFG_ISN:    isn_q      <= cfg_data;
					tswr_pkg::CFG_RTO:    init_rto_q <= cfg_data[15:0];
					tswr_pkg::CFG_MAXPAY: max_pay_q  <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (out_load) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			if (cmd.push_step) begin
				stg_v_q <= 1'b1;
				tail_q  <= ptr_inc(tail_q);
				cnt_q   <= cnt_q + 1'b1;
				if (seg_fin) fin_q <= 1'b1;
				if (seg_syn) syn_q <= 1'b1;
				flight_q <= new_seg.in_flight;
				next_q   <= next_q + {52'd0, seg_len};
			end
			if (cmd.push_flush) stg_v_q <= 1'b0;
			if (cmd.ack_rst) err_q <= 1'b1;
			if (cmd.ack_win) pw_q <= win_in_q;
			if (cmd.ack_commit) begin
				timer_q    <= '0;
				retry_q    <= '0;
				rto_q      <= {16'd0, init_rto_q};
				last_ack_q <= ack_q;
			end
			if (cmd.q_pop) begin
				flight_q <= flight_after;
				head_q   <= ptr_inc(head_q);
				cnt_q    <= cnt_q - 1'b1;
			end
			if (cmd.tick_add) timer_q <= timer_sum[32] ? '1 : timer_sum[31:0];
			if (cmd.tick_fire) begin
				timer_q <= '0;
				if (pw_q != '0) begin
					rto_q   <= rto_dbl;
					retry_q <= retry_inc;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= in_op;
			ackv_q   <= in_data[0];
			ackno_q  <= in_data[32:1];
			win_in_q <= in_data[48:33];
			prst_q   <= in_data[49];
			avail_q  <= in_data[65:50];
			fin_in_q <= in_data[66];
			serr_q   <= in_data[67];
			el_q     <= in_data[83:68];
			nseg_q   <= '0;
		end
		if (cmd.push_step) begin
			// queue keeps the unwrapped low bits; the isn is added on resend
			mem[tail_q] <= '{seqno: next_q[31:0], payload: new_seg.payload,
			                 syn: new_seg.syn, fin: new_seg.fin, rst: new_seg.rst};
			avail_q <= avail_left;
			nseg_q  <= nseg_q + 1'b1;
			stg_q   <= new_seg;
			if (stg_v_q) out_q <= stg_q;
		end
		if (cmd.push_flush) out_q <= flush_res;
		if (cmd.ack_unwrap) ack_q <= ack_un;
		if (cmd.ack_unwrap) in_range_q <= 1'b0;
		if (cmd.ack_unwrap) dist_q <= '0;
		if (cmd.ack_commit) dist_q <= next_q[16:0] - ack_q[16:0];
		if (cmd.q_rd) rd_q <= mem[head_q];
		if (cmd.tick_fire) begin
			out_q.seqno      <= rd_q.seqno + isn_q;
			out_q.syn        <= rd_q.syn;
			out_q.fin        <= rd_q.fin;
			out_q.rst        <= rd_q.rst;
			out_q.payload    <= rd_q.payload;
			out_q.retx       <= 1'b1;
			out_q.last       <= 1'b1;
			out_q.in_flight  <= flight_q;
			out_q.retx_count <= (pw_q != '0) ? retry_inc : retry_q;
		end
		if (cmd.empty_fire) begin
			out_q.seqno      <= next_q[31:0] + isn_q;
			out_q.syn        <= 1'b0;
			out_q.fin        <= 1'b0;
			out_q.rst        <= err_q || serr_q;
			out_q.payload    <= '0;
			out_q.retx       <= 1'b0;
			out_q.last       <= 1'b1;
			out_q.in_flight  <= flight_q;
			out_q.retx_count <= retry_q;
		end
	end

	logic ack_ok;
	assign ack_ok = !(ack_q > next_q) && (ack_q > last_ack_q);

	assign out_valid = out_v_q;
	assign res       = out_q;

	always_comb begin
		sts.op           = tswr_pkg::op_t'(op_q);
		sts.ackno_valid  = ackv_q;
		sts.peer_reset   = prst_q;
		sts.seg_ok       = seg_ok;
		sts.stg_valid    = stg_v_q;
		sts.out_free     = out_free;
		sts.q_empty      = (cnt_q == '0);
		sts.ack_in_range = ack_ok && !in_range_q;
		sts.pop_ok       = flight_after >= dist_q && flight_q >= {5'd0, rd_len};
		sts.timer_exp    = timer_q >= rto_q;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_flight_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) == (flight_q == '0))
		else $error("flight and queue occupancy disagree");

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("fin_done cleared");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick_fire || cmd.empty_fire || cmd.push_flush) |-> out_free)
		else $error("result loaded over a waiting result");

endmodule

// ===== hw/rtl/tcp_sender_window_retransmit_core.sv =====
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: input fields, tuser: op
// m_axis    out  m_axis_tvalid/tready       tdata: segment, tuser: retransmit, tlast
// cfg       in   cfg_we (no wait)           cfg_idx, cfg_data
//
// Push: latch, decode, a step per segment, then flush the last one or find none.
// Ack: ends after decode on peer reset or no ackno, after the range check if stale
// or out of range; if taken, each acked entry is read and popped (registered read).
// Tick: on a non-empty queue, a timer add and then an expiry check. One at a time.
// Reset: arst_n clears control and protocol state; queue contents are not cleared.
// A stalled m_axis holds every push step, a resend and an empty message result;
// the next input is taken while the last result of an item still waits.
module tcp_sender_window_retransmit_core #(
	parameter int QUEUE_DEPTH  = tswr_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_SEGMENTS = tswr_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_idx,
	input  logic [31:0]                    cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// ackno_valid, ackno, window, peer_reset, bytes_available,
	// stream_finished, stream_error, elapsed_ms, zero pad
	input  logic [tswr_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  logic [1:0]                     s_axis_tuser,   // op
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// seg_seqno, seg_syn, seg_fin, seg_rst, payload_len, in_flight,
	// retx_count, zero pad
	output logic [tswr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tuser,   // is_retransmit
	output logic                           m_axis_tlast
);

	tswr_pkg::cmd_t cmd;
	tswr_pkg::sts_t sts;
	tswr_pkg::res_t res;

	tswr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tswr_dp #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_op     (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.res       (res),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign m_axis_tdata = {1'b0, res.retx_count, res.in_flight, res.payload,
	                       res.rst, res.fin, res.syn, res.seqno};
	assign m_axis_tuser = res.retx;
	assign m_axis_tlast = res.last;

endmodule

// ===== dv/tcp_sender_window_retransmit_core_tb.sv =====
`timescale 1ns / 100ps

module tcp_sender_window_retransmit_core_tb;

	localparam int QDEPTH  = tswr_pkg::QUEUE_DEPTH_DEF;
	localparam int SEG_CAP = tswr_pkg::MAX_SEGMENTS_DEF;
	localparam int SETTLE  = 300;   // covers an ack that pops a full queue

	// one input transaction, unpacked
	typedef struct {
		tswr_pkg::op_t op;
		bit          ackv;
		bit [31:0]   ackno;
		bit [15:0]   win;
		bit          prst;
		bit [15:0]   avail;
		bit          sfin;
		bit          serr;
		bit [15:0]   el;
	} item_t;

	// one segment descriptor as it should leave the block
	typedef struct {
		bit [31:0] seqno;
		bit        syn, fin, rst;
		bit [10:0] payload;
		bit        retx, last;
		bit [16:0] in_flight;
		bit [7:0]  retx_count;
	} seg_desc_t;

	// outstanding segment in the model's retransmit queue
	typedef struct {
		bit [63:0] abs_seq;
		bit [16:0] len;
		bit [10:0] payload;
		bit        syn, fin, rst;
	} flight_ent_t;

	// directed stimulus row; chk marks a row with its one result typed in
	typedef struct {
		item_t     it;
		bit        chk;
		seg_desc_t want;
	} row_t;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_we = 0;
	logic [1:0]            cfg_idx = '0;
	logic [31:0]           cfg_data = '0;
	logic                  s_axis_tvalid = 0;
	logic                  s_axis_tready;
	logic [tswr_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 0;
	logic [tswr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	tcp_sender_window_retransmit_core uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// model configuration
	bit [31:0] m_isn;
	bit [15:0] m_init_rto;
	bit [10:0] m_maxpay;
	// model protocol state
	bit [63:0] next_seq, last_ack;
	bit [16:0] flight;
	bit [15:0] peer_win;
	bit        syn_sent, fin_sent, err_seen;
	bit [31:0] timer_acc, rto_cur;
	bit [7:0]  retries;
	flight_ent_t outstanding[$];

	seg_desc_t seg_expected[$];
	int        errors = 0;
	bit        calm   = 0;    // no idling on either side
	int        sink_hold = 0;

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic seg_desc_t describe(flight_ent_t e, bit retx);
		seg_desc_t d;
		d.seqno      = e.abs_seq[31:0] + m_isn;
		d.syn        = e.syn;
		d.fin        = e.fin;
		d.rst        = e.rst;
		d.payload    = e.payload;
		d.retx       = retx;
		d.last       = 0;
		d.in_flight  = flight;
		d.retx_count = retries;
		return d;
	endfunction

	function automatic bit [63:0] unwrap_ack(bit [31:0] w, bit [63:0] ckpt);
		bit [63:0] cand;
		cand = {ckpt[63:32], w - m_isn};
		if (cand > ckpt + 64'h8000_0000 && cand >= 64'h1_0000_0000)
			cand -= 64'h1_0000_0000;
		else if (cand + 64'h8000_0000 < ckpt)
			cand += 64'h1_0000_0000;
		return cand;
	endfunction

	// advance the model by one accepted input and queue the segments it yields
	function automatic void predict_segments(item_t it);
		seg_desc_t   got[$];
		flight_ent_t e;
		bit [31:0]   wnd, room, take, left;
		bit [63:0]   ack;
		case (it.op)
			tswr_pkg::OP_PUSH: begin
				wnd  = (peer_win == 0) ? 32'd1 : {16'd0, peer_win};
				left = {16'd0, it.avail};
				while (wnd > {15'd0, flight} && !fin_sent && got.size() < SEG_CAP &&
						outstanding.size() < QDEPTH) begin
					room      = wnd - {15'd0, flight};
					e.abs_seq = next_seq;
					e.syn     = !syn_sent;
					e.fin     = 0;
					e.rst     = err_seen | it.serr;
					if (e.syn) room--;
					take = room;
					if (left < take) take = left;
					if ({21'd0, m_maxpay} < take) take = {21'd0, m_maxpay};
					left -= take;
					room -= take;
					if (room > 0 && it.sfin && left == 0) e.fin = 1;
					e.payload = take[10:0];
					e.len     = take[16:0] + {16'd0, e.syn} + {16'd0, e.fin};
					if (e.len == 0) break;
					outstanding = {outstanding, e};
					if (e.fin) fin_sent = 1;
					if (e.syn) syn_sent = 1;
					flight   += e.len;
					next_seq += {47'd0, e.len};
					got = {got, describe(e, 0)};
				end
			end
			tswr_pkg::OP_ACK: begin
				if (it.prst) begin
					err_seen = 1;
				end else begin
					ack      = it.ackv ? unwrap_ack(it.ackno, next_seq) : last_ack;
					peer_win = it.win;
					if (!(ack > next_seq || ack <= last_ack)) begin
						timer_acc = 0;
						retries   = 0;
						rto_cur   = {16'd0, m_init_rto};
						while (outstanding.size() > 0 && outstanding[0].abs_seq +
								{47'd0, outstanding[0].len} <= ack) begin
							flight -= outstanding[0].len;
							outstanding.delete(0);
						end
						last_ack = ack;
					end
				end
			end
			tswr_pkg::OP_TICK: begin
				if (outstanding.size() > 0) begin
					timer_acc = (timer_acc > 32'hFFFF_FFFF - {16'd0, it.el}) ?
						32'hFFFF_FFFF : timer_acc + {16'd0, it.el};
					if (timer_acc >= rto_cur) begin
						timer_acc = 0;
						if (peer_win != 0) begin
							rto_cur = (rto_cur > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF :
								{rto_cur[30:0], 1'b0};
							if (retries != 8'hFF) retries = retries + 8'd1;
						end
						got = {got, describe(outstanding[0], 1)};
					end
				end
			end
			default: begin
				e = '{abs_seq: next_seq, len: 0, payload: 0, syn: 0, fin: 0,
					rst: err_seen | it.serr};
				got = {got, describe(e, 0)};
			end
		endcase
		if (got.size() > 0) got[$].last = 1;
		seg_expected = {seg_expected, got};
	endfunction

	task automatic write_reg(input tswr_pkg::cfg_idx_t idx, input bit [31:0] val);
		@(negedge clk);
		cfg_we   <= 1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			tswr_pkg::CFG_ISN:    m_isn      = val;
			tswr_pkg::CFG_RTO:    m_init_rto = val[15:0];
			tswr_pkg::CFG_MAXPAY: m_maxpay   = val[10:0];
			default: ;
		endcase
	endtask

	// hand one item over the input stream; called and returning at a falling edge
	task automatic send_item(input item_t it, input bit chk, input seg_desc_t want);
		int n;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= it.op;
		s_axis_tdata  <= {4'd0, it.el, it.serr, it.sfin, it.avail, it.prst, it.win,
			it.ackno, it.ackv};
		do @(posedge clk); while (!s_axis_tready);
		n = seg_expected.size();
		predict_segments(it);
		if (chk) begin
			while (seg_expected.size() > n) void'(seg_expected.pop_back());
			seg_expected = {seg_expected, want};
		end
		@(negedge clk);
	endtask

	// block must be idle before a register write; called at a falling edge
	task automatic drain();
		s_axis_tvalid <= 0;
		while (seg_expected.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// sink side: random back-pressure, none when calm
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_axis_tready <= 0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			sink_hold = $urandom_range(0, 2);
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
		end
	end

	// result checker
	always @(posedge clk) begin
		seg_desc_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (seg_expected.size() == 0) begin
				report($sformatf("unexpected segment seqno %h", m_axis_tdata[31:0]));
			end else begin
				w = seg_expected[0];
				seg_expected.delete(0);
				if (m_axis_tdata[31:0] !== w.seqno)
					report($sformatf("seqno %h, want %h", m_axis_tdata[31:0], w.seqno));
				if (m_axis_tdata[32] !== w.syn)  report("syn flag");
				if (m_axis_tdata[33] !== w.fin)  report("fin flag");
				if (m_axis_tdata[34] !== w.rst)  report("rst flag");
				if (m_axis_tdata[45:35] !== w.payload)
					report($sformatf("payload %0d, want %0d", m_axis_tdata[45:35], w.payload));
				if (m_axis_tuser !== w.retx)     report("retransmit flag");
				if (m_axis_tlast !== w.last)     report("tlast");
				if (m_axis_tdata[62:46] !== w.in_flight)
					report($sformatf("in_flight %0d, want %0d", m_axis_tdata[62:46],
						w.in_flight));
				if (m_axis_tdata[70:63] !== w.retx_count)
					report($sformatf("retx_count %0d, want %0d", m_axis_tdata[70:63],
						w.retx_count));
			end
		end
	end

	function automatic item_t mk(tswr_pkg::op_t op, bit ackv, bit [31:0] ackno,
			bit [15:0] win, bit prst, bit [15:0] avail, bit sfin, bit serr, bit [15:0] el);
		item_t it;
		it = '{op, ackv, ackno, win, prst, avail, sfin, serr, el};
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t     it;
		bit [63:0] span;
		it = mk(tswr_pkg::OP_PUSH, $urandom_range(0, 9) != 0, $urandom(),
			16'($urandom()), 0, 16'($urandom()), 0, 0, 16'($urandom()));
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6: it.op = tswr_pkg::OP_PUSH;
			7, 8, 9, 10, 11, 12: it.op = tswr_pkg::OP_ACK;
			13, 14, 15, 16, 17:  it.op = tswr_pkg::OP_TICK;
			default:             it.op = tswr_pkg::OP_EMPTY;
		endcase
		case ($urandom_range(0, 4))
			0:       it.win = 0;
			1, 2:    it.win = 16'($urandom_range(1, 60));
			default: it.win = 16'($urandom());
		endcase
		if ($urandom_range(0, 1)) it.avail = 16'($urandom_range(0, 3000));
		it.sfin = $urandom_range(0, 4) == 0;
		it.serr = $urandom_range(0, 9) == 0;
		it.prst = $urandom_range(0, 29) == 0;
		if ($urandom_range(0, 1)) it.el = 16'($urandom_range(0, 3 * rto_cur[15:0]));
		// mostly an ack that lands inside the outstanding range
		span = next_seq - last_ack;
		if (span != 0 && $urandom_range(0, 5) != 0)
			it.ackno = m_isn + last_ack[31:0] + $urandom_range(1, span[31:0]);
		return it;
	endfunction

	row_t dir_rows[$];

	function automatic void add_row(item_t it, bit chk, seg_desc_t want);
		row_t r;
		r.it   = it;
		r.chk  = chk;
		r.want = want;
		dir_rows = {dir_rows, r};
	endfunction

	initial begin
		item_t     it;
		seg_desc_t none;
		bit [31:0] isn_v[4], rto_v[4], mp_v[4];
		none = '{default: 0};
		// model reset
		m_isn = 0; m_init_rto = tswr_pkg::RTO_RESET; m_maxpay = tswr_pkg::MAXPAY_RESET;
		next_seq = 0; last_ack = 0; flight = 0; peer_win = 1;
		syn_sent = 0; fin_sent = 0; err_seen = 0;
		timer_acc = 0; rto_cur = {16'd0, tswr_pkg::RTO_RESET}; retries = 0;

		// first push after reset: window of one carries the SYN alone
		add_row(mk(tswr_pkg::OP_PUSH, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			'{32'd0, 1, 0, 0, 11'd0, 0, 1, 17'd1, 8'd0});
		add_row(mk(tswr_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 16'd999), 0, none);
		// timer reaches the reset RTO: SYN goes again, retries to one
		add_row(mk(tswr_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 16'd1), 1,
			'{32'd0, 1, 0, 0, 11'd0, 1, 1, 17'd1, 8'd1});
		// empty message with stream error
		add_row(mk(tswr_pkg::OP_EMPTY, 0, 0, 0, 0, 0, 0, 1, 0), 1,
			'{32'd1, 0, 0, 1, 11'd0, 0, 1, 17'd1, 8'd1});
		add_row(mk(tswr_pkg::OP_ACK, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(tswr_pkg::OP_PUSH, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0), 0, none);
		add_row(mk(tswr_pkg::OP_ACK, 1, 32'd1, 16'hFFFF, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(tswr_pkg::OP_PUSH, 0, 0, 0, 0, 16'hFFFF, 1, 0, 0), 0, none);
		add_row(mk(tswr_pkg::OP_ACK, 1, 32'd0, 16'hFFFF, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(tswr_pkg::OP_ACK, 1, 32'h7FFF_FFFF, 16'd0, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(tswr_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, none);
		add_row(mk(tswr_pkg::OP_ACK, 1, 32'd3000, 16'd500, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(tswr_pkg::OP_PUSH, 0, 0, 0, 0, 16'd900, 1, 0, 0), 0, none);
		add_row(mk(tswr_pkg::OP_ACK, 1, 32'hFFFF_FFFF, 16'hFFFF, 1, 16'hFFFF, 1, 1,
			16'hFFFF), 0, none);
		add_row(mk(tswr_pkg::OP_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(tswr_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, none);
		add_row(mk(tswr_pkg::OP_ACK, 1, 32'd70000, 16'd0, 0, 0, 0, 0, 0), 0, none);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].want);
		drain();
		write_reg(tswr_pkg::CFG_NONE, 32'hFFFF_FFFF);

		// settings per phase: extremes of each register, then odd values
		isn_v = '{$urandom(), 32'hFFFF_FFFF, 32'h0, $urandom()};
		rto_v = '{32'd1, 32'd65535, 32'd0, $urandom_range(2, 400)};
		mp_v  = '{32'd1, 32'd1460, 32'd0, 32'd2047};
		for (int ph = 0; ph < 4; ph++) begin
			// new isn only makes sense on a fresh connection view; the model follows it
			write_reg(tswr_pkg::CFG_ISN, isn_v[ph]);
			write_reg(tswr_pkg::CFG_RTO, rto_v[ph]);
			write_reg(tswr_pkg::CFG_MAXPAY, mp_v[ph]);
			for (int k = 0; k < 100; k++) begin
				if (ph == 3 && k >= 60) calm = 1;
				it = rand_item();
				send_item(it, 0, none);
			end
			drain();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
